@@ sv/bdq_pkg.sv @@
package bdq_pkg;

  // Operation codes carried by an input item.
  localparam logic [2:0] OP_ADD_FRONT = 3'd0;
  localparam logic [2:0] OP_ADD_BACK  = 3'd1;
  localparam logic [2:0] OP_REM_FRONT = 3'd2;
  localparam logic [2:0] OP_REM_BACK  = 3'd3;
  localparam logic [2:0] OP_SEARCH    = 3'd4;

  // One input item.
  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] item_value;
  } request_t;

  // One result item.
  typedef struct packed {
    logic       succeeded;
    logic [4:0] count_now;
    logic       store_empty;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic add_front;
    logic add_back;
    logic rem_front;
    logic rem_back;
    logic search_start;
    logic search_step;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic scan_done;
  } dp_status_t;

endpackage

@@ sv/bdq_dpath.sv @@
module bdq_dpath #(
  parameter int CAPACITY = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bdq_pkg::dp_cmd_t             cmd,
  input  logic signed [31:0]           item_value,
  output bdq_pkg::dp_status_t          status,
  output logic [$clog2(CAPACITY+1)-1:0] count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [31:0]   value_reg;
  logic [AW-1:0] head;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] scan_ptr;
  logic [AW-1:0] scan_inc;
  logic [CW-1:0] scan_cnt;
  logic [CW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic [31:0]   mem [CAPACITY];

  // Ring neighbors of the head and of the scan pointer.
  assign head_dec = (head == '0) ? AW'(CAPACITY - 1) : head - AW'(1);
  assign head_inc = (head == AW'(CAPACITY - 1)) ? '0 : head + AW'(1);
  assign scan_inc = (scan_ptr == AW'(CAPACITY - 1)) ? '0 : scan_ptr + AW'(1);

  // Slot just past the back entry; the sum stays below twice the capacity.
  assign tail_sum = (CW+1)'(head) + (CW+1)'(count);
  always_comb begin
    if (tail_sum >= (CW+1)'(CAPACITY)) begin
      tail = AW'(tail_sum - (CW+1)'(CAPACITY));
    end else begin
      tail = AW'(tail_sum);
    end
  end

  assign wr_en   = cmd.add_front | cmd.add_back;
  assign wr_addr = cmd.add_front ? head_dec : tail;
  assign rd_addr = cmd.search_start ? head : scan_ptr;

  // Entry store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value_reg;
    end
    rd_data <= mem[rd_addr];
  end

  // Item value and search walk registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_reg <= item_value;
    end
    if (cmd.search_start) begin
      scan_ptr <= head_inc;
      scan_cnt <= CW'(1);
    end else if (cmd.search_step) begin
      scan_ptr <= scan_inc;
      scan_cnt <= scan_cnt + CW'(1);
    end
  end

  // Head position and entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (cmd.add_front) begin
        head  <= head_dec;
        count <= count + CW'(1);
      end else if (cmd.add_back) begin
        count <= count + CW'(1);
      end else if (cmd.rem_front) begin
        head  <= head_inc;
        count <= count - CW'(1);
      end else if (cmd.rem_back) begin
        count <= count - CW'(1);
      end
    end
  end

  assign status.full      = (count == CW'(CAPACITY));
  assign status.empty     = (count == '0);
  assign status.match     = (rd_data == value_reg);
  assign status.scan_done = (scan_cnt == count);

endmodule

@@ sv/bdq_ctrl.sv @@
module bdq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2:0]          opcode,
  input  bdq_pkg::dp_status_t status,
  output bdq_pkg::dp_cmd_t    cmd,
  output logic                busy,
  output logic                done,
  output logic                ok
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [2:0] op;
  logic       done_next;
  logic       ok_next;

  assign busy = (state != ST_IDLE);

  // Next state, commands and result flag.
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    ok_next    = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (opcode > bdq_pkg::OP_SEARCH) begin
            // Unused code: report the current state at once.
            done_next = 1'b1;
          end else begin
            state_next = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        state_next = ST_IDLE;
        done_next  = 1'b1;
        unique case (op)
          bdq_pkg::OP_ADD_FRONT: begin
            cmd.add_front = !status.full;
            ok_next       = !status.full;
          end
          bdq_pkg::OP_ADD_BACK: begin
            cmd.add_back = !status.full;
            ok_next      = !status.full;
          end
          bdq_pkg::OP_REM_FRONT: begin
            cmd.rem_front = !status.empty;
            ok_next       = !status.empty;
          end
          bdq_pkg::OP_REM_BACK: begin
            cmd.rem_back = !status.empty;
            ok_next      = !status.empty;
          end
          bdq_pkg::OP_SEARCH: begin
            if (!status.empty) begin
              cmd.search_start = 1'b1;
              state_next       = ST_SCAN;
              done_next        = 1'b0;
            end
          end
          default: begin
            ok_next = 1'b0;
          end
        endcase
      end
      ST_SCAN: begin
        // The read data holds the entry fetched in the previous cycle.
        if (status.match) begin
          ok_next    = 1'b1;
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else if (status.scan_done) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      ok    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      ok    <= ok_next;
      if (cmd.load) begin
        op <= opcode;
      end
    end
  end

endmodule

@@ sv/bounded_deque_with_search_top.sv @@
// Bounded double-ended queue of signed 32-bit values with a search operation.
// An item is taken on request when start is high and busy is low. Its opcode
// adds at the front or back, removes at the front or back, or searches the
// stored entries for item_value. Every item gives exactly one result, shown on
// result for the single cycle in which done is high; the receiver cannot stall
// and must take it then. The result carries the success flag, the entry count
// after the operation and an empty flag.
// An unused opcode reports in the next cycle and never raises busy.
// An add or remove acts in the update state and then reports. A search
// walks the stored entries from the front, stopping at the first match or
// after the last entry; the entry store has one read port and the walk
// fetches one entry per cycle. A new item may be started in the cycle that
// shows done.
// Reset (rst, synchronous) empties the queue and returns the head to slot 0;
// the entry store itself is not cleared, as no entry is read before written.
module bounded_deque_with_search_top #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bdq_pkg::request_t request,
  output logic              busy,
  output logic              done,
  output bdq_pkg::result_t  result
);

  localparam int CW = $clog2(CAPACITY + 1);

  bdq_pkg::dp_cmd_t    cmd;
  bdq_pkg::dp_status_t status;
  logic [CW-1:0]       count;
  logic                ok;

  bdq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (request.opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .ok     (ok)
  );

  bdq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .item_value (request.item_value),
    .status     (status),
    .count      (count)
  );

  // Result assembly; the count register already holds the post-operation value.
  assign result.succeeded   = ok;
  assign result.count_now   = 5'(count);
  assign result.store_empty = status.empty;

  // A result is only shown while the block is ready for the next item.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // The entry count never exceeds the capacity.
  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // An accepted item with a valid opcode keeps the block busy next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.opcode <= bdq_pkg::OP_SEARCH)) |=> busy)
    else $error("valid item did not start work");

  // A successful add never leaves the queue empty.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.add_front || cmd.add_back) |=> (count != '0))
    else $error("add left queue empty");

endmodule

@@ dv/tb_bounded_deque_with_search_top.sv @@
`timescale 1ns / 1ps

module tb_bounded_deque_with_search_top;

  localparam int DEPTH       = 16;
  localparam int ITEM_GOAL   = 1200;
  localparam int DRAIN_LIMIT = 4000;

  // Opcodes the block leaves unused; they must report without touching the queue.
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  typedef enum {FILLING, DRAINING, MIXING} burst_kind_t;

  typedef struct {
    bdq_pkg::request_t rq;
    bit                typed;
    bdq_pkg::result_t  want;
  } script_row_t;

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              start   = 1'b0;
  bdq_pkg::request_t request = '0;
  logic              busy;
  logic              done;
  bdq_pkg::result_t  result;

  // Shadow copy of the deque contents, kept in step with accepted items.
  logic signed [31:0] ring_copy [DEPTH];
  logic [3:0]         front_idx  = '0;
  logic [4:0]         fill_count = '0;

  bdq_pkg::result_t pending_results [$];
  script_row_t      script [$];

  int n_errors        = 0;
  int n_items         = 0;
  int n_results       = 0;
  int n_search_hits   = 0;
  int n_full_refusals = 0;
  int n_empty_refusals = 0;
  int n_spare_ops     = 0;

  always #4 clk = ~clk;

  bounded_deque_with_search_top #(
    .CAPACITY(DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // Apply one accepted item to the shadow deque and return the result it should give.
  function automatic bdq_pkg::result_t apply_request(bdq_pkg::request_t rq);
    bdq_pkg::result_t r;
    logic [3:0]       slot;
    r.succeeded = 1'b0;
    case (rq.opcode)
      bdq_pkg::OP_ADD_FRONT: begin
        if (fill_count < DEPTH) begin
          front_idx            = front_idx - 4'd1;
          ring_copy[front_idx] = rq.item_value;
          fill_count           = fill_count + 5'd1;
          r.succeeded          = 1'b1;
        end
      end
      bdq_pkg::OP_ADD_BACK: begin
        if (fill_count < DEPTH) begin
          slot            = front_idx + fill_count[3:0];
          ring_copy[slot] = rq.item_value;
          fill_count      = fill_count + 5'd1;
          r.succeeded     = 1'b1;
        end
      end
      bdq_pkg::OP_REM_FRONT: begin
        if (fill_count != 0) begin
          front_idx   = front_idx + 4'd1;
          fill_count  = fill_count - 5'd1;
          r.succeeded = 1'b1;
        end
      end
      bdq_pkg::OP_REM_BACK: begin
        if (fill_count != 0) begin
          fill_count  = fill_count - 5'd1;
          r.succeeded = 1'b1;
        end
      end
      bdq_pkg::OP_SEARCH: begin
        for (int k = 0; k < fill_count; k++) begin
          slot = front_idx + 4'(k);
          if (ring_copy[slot] == rq.item_value) r.succeeded = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.count_now   = fill_count;
    r.store_empty = (fill_count == 0);
    return r;
  endfunction

  function automatic void add_row(logic [2:0] op, logic [31:0] val, bit typed,
                                  logic ok, logic [4:0] cnt, logic emp);
    script_row_t row;
    row.rq.opcode     = op;
    row.rq.item_value = val;
    row.typed         = typed;
    row.want          = '{succeeded: ok, count_now: cnt, store_empty: emp};
    script.push_back(row);
  endfunction

  // Mostly short gaps, sometimes long ones; calm bursts run back to back.
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Values lean toward extremes and a small set so that searches hit often.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5: return 32'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  // Drive one item, hold it until the block takes it, then record its expectation.
  task automatic send(bdq_pkg::request_t rq, int gap, bit typed, bdq_pkg::result_t want);
    bdq_pkg::result_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= rq;
    do @(posedge clk); while (busy);
    predicted = apply_request(rq);
    pending_results.push_back(typed ? want : predicted);
    n_items++;
    if (rq.opcode == bdq_pkg::OP_SEARCH && predicted.succeeded) n_search_hits++;
    if ((rq.opcode == bdq_pkg::OP_ADD_FRONT || rq.opcode == bdq_pkg::OP_ADD_BACK) &&
        !predicted.succeeded)
      n_full_refusals++;
    if ((rq.opcode == bdq_pkg::OP_REM_FRONT || rq.opcode == bdq_pkg::OP_REM_BACK) &&
        !predicted.succeeded)
      n_empty_refusals++;
    if (rq.opcode > bdq_pkg::OP_SEARCH) n_spare_ops++;
  endtask

  // Each strobed result is compared with the oldest outstanding expectation.
  always @(posedge clk) begin
    bdq_pkg::result_t want;
    if (!rst && done) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending: got ok=%0b count=%0d empty=%0b",
                 $time, result.succeeded, result.count_now, result.store_empty);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (result.succeeded !== want.succeeded || result.count_now !== want.count_now ||
            result.store_empty !== want.store_empty) begin
          $display("%0t: mismatch: expected ok=%0b count=%0d empty=%0b,",
                   $time, want.succeeded, want.count_now, want.store_empty);
          $display("%0t:           got ok=%0b count=%0d empty=%0b",
                   $time, result.succeeded, result.count_now, result.store_empty);
          n_errors++;
        end
      end
    end
  end

  // Stimulus: a directed script, then bursts of random items.
  initial begin
    bdq_pkg::request_t rq;
    burst_kind_t       kind;
    bit                calm;
    int                burst_len;
    int                r;
    int                idx;
    int                waited;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty queue: refusals and unused opcode, then the value extremes.
    add_row(bdq_pkg::OP_REM_FRONT, 32'h0, 1, 1'b0, 5'd0, 1'b1);
    add_row(bdq_pkg::OP_REM_BACK,  32'h0, 1, 1'b0, 5'd0, 1'b1);
    add_row(bdq_pkg::OP_SEARCH,    32'h0, 1, 1'b0, 5'd0, 1'b1);
    add_row(OP_SPARE_A,            32'h0, 1, 1'b0, 5'd0, 1'b1);
    add_row(bdq_pkg::OP_ADD_FRONT, 32'h7fff_ffff, 1, 1'b1, 5'd1, 1'b0);
    add_row(bdq_pkg::OP_ADD_BACK,  32'h8000_0000, 1, 1'b1, 5'd2, 1'b0);
    add_row(bdq_pkg::OP_SEARCH,    32'h8000_0000, 1, 1'b1, 5'd2, 1'b0);
    add_row(OP_SPARE_C,            32'hffff_ffff, 1, 1'b0, 5'd2, 1'b0);
    // Fill to capacity from both ends so the head wraps, then add once more.
    for (int k = 0; k < DEPTH - 2; k++)
      add_row((k % 2) ? bdq_pkg::OP_ADD_BACK : bdq_pkg::OP_ADD_FRONT, $urandom, 0,
              1'b0, 5'd0, 1'b0);
    add_row(bdq_pkg::OP_ADD_BACK,  32'h1, 1, 1'b0, 5'd16, 1'b0);
    add_row(bdq_pkg::OP_SEARCH,    32'h7fff_ffff, 0, 1'b0, 5'd0, 1'b0);
    add_row(bdq_pkg::OP_REM_BACK,  32'h0, 0, 1'b0, 5'd0, 1'b0);

    foreach (script[i]) send(script[i].rq, pick_gap(0), script[i].typed, script[i].want);

    // Random bursts that push the queue toward full, toward empty, or stir it.
    while (n_items < ITEM_GOAL + script.size()) begin
      kind      = burst_kind_t'($urandom_range(0, 2));
      calm      = ($urandom_range(0, 3) == 0);
      burst_len = $urandom_range(10, 40);
      for (int b = 0; b < burst_len; b++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          rq.opcode = 3'($urandom_range(bdq_pkg::OP_SEARCH + 1, OP_SPARE_C));
        end else begin
          r = $urandom_range(0, 99);
          case (kind)
            FILLING:  rq.opcode = (r < 70) ? bdq_pkg::OP_ADD_FRONT :
                                  (r < 85) ? bdq_pkg::OP_REM_FRONT : bdq_pkg::OP_SEARCH;
            DRAINING: rq.opcode = (r < 65) ? bdq_pkg::OP_REM_FRONT :
                                  (r < 80) ? bdq_pkg::OP_ADD_FRONT : bdq_pkg::OP_SEARCH;
            default:  rq.opcode = (r < 35) ? bdq_pkg::OP_SEARCH :
                                  (r < 70) ? bdq_pkg::OP_ADD_FRONT : bdq_pkg::OP_REM_FRONT;
          endcase
          // Choose between the front and back flavor of adds and removes.
          if (rq.opcode != bdq_pkg::OP_SEARCH && $urandom_range(0, 1))
            rq.opcode = rq.opcode + 3'd1;
        end
        rq.item_value = pick_value();
        if (rq.opcode == bdq_pkg::OP_SEARCH && fill_count != 0 && $urandom_range(0, 1)) begin
          idx           = $urandom_range(0, fill_count - 1);
          rq.item_value = ring_copy[front_idx + 4'(idx)];
        end
        send(rq, pick_gap(calm), 0, '0);
      end
    end
    start <= 1'b0;

    // Let outstanding results arrive, then keep watching for stray strobes.
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DEPTH + 4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      n_errors++;
    end

    $display("Sent %0d items, checked %0d results, %0d search hits.",
             n_items, n_results, n_search_hits);
    $display("Refused adds on full: %0d, refused removes on empty: %0d, unused opcodes: %0d.",
             n_full_refusals, n_empty_refusals, n_spare_ops);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
sv/bdq_pkg.sv
sv/bdq_dpath.sv
sv/bdq_ctrl.sv
sv/bounded_deque_with_search_top.sv
dv/tb_bounded_deque_with_search_top.sv
